@@ rtl/core/itsw_pkg.sv @@
// ----------------------------------------------------------------------------
// itsw_pkg
// Shared types and codes for the three-channel interval timer.
// ----------------------------------------------------------------------------
package itsw_pkg;

    localparam int NUM_CHANNELS = 3;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] PORT_CTRL = 2'd3;

    localparam logic [1:0] ACC_LATCH = 2'd0;
    localparam logic [1:0] ACC_LOW   = 2'd1;
    localparam logic [1:0] ACC_HIGH  = 2'd2;
    localparam logic [1:0] ACC_PAIR  = 2'd3;

    localparam logic [1:0] PTR_LOW         = 2'd0;
    localparam logic [1:0] PTR_HIGH        = 2'd1;
    localparam logic [1:0] PTR_PAIR_FIRST  = 2'd2;
    localparam logic [1:0] PTR_PAIR_SECOND = 2'd3;

    localparam logic [2:0] MODE_SQUARE     = 3'd3;
    localparam logic [2:0] MODE_SQUARE_ALT = 3'd7;

    localparam logic [16:0] FULL_COUNT = 17'h10000;

    typedef struct packed {
        logic       wr_ctrl;
        logic       wr_data;
        logic       tick;
        logic [7:0] data;
    } t_chan_op;

    typedef struct packed {
        logic [7:0] rd_byte;
        logic       lvl;
        logic       lvl_next;
    } t_chan_stat;

endpackage

@@ rtl/core/interval_timer_square_wave.sv @@
// ----------------------------------------------------------------------------
// interval_timer_square_wave
// Three-channel interval timer with bus access and tick commands.
// ----------------------------------------------------------------------------
// Each item passes through an input register, updates the channel state in
// combinational logic and leaves through a result register, so the block takes
// one item per cycle while the downstream side does not stall. Every item
// yields exactly one result: the read byte, the channel 0 rising-edge flag
// and the level of channel 2. A result register that is held by the downstream
// side stops the input register, which in turn stalls the upstream side.
module interval_timer_square_wave (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [1:0] i_port,
    input  logic [7:0] i_write_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_data,
    output logic       o_irq0,
    output logic       o_timer2_out
);

    localparam int NCH = itsw_pkg::NUM_CHANNELS;

    logic       r_in_vld;
    logic [1:0] r_in_cmd;
    logic [1:0] r_in_port;
    logic [7:0] r_in_data;
    logic       r_out_vld;
    logic [7:0] r_out_rd;
    logic       r_out_irq;
    logic       r_out_t2;

    logic       accept;
    logic       adv;
    logic [7:0] rd_byte;
    logic       irq;
    logic       t2;

    itsw_pkg::t_chan_op   op   [NCH];
    itsw_pkg::t_chan_stat stat [NCH];

    assign o_stall = r_in_vld && r_out_vld && i_stall;
    assign accept  = i_valid && !o_stall;
    assign adv     = r_in_vld && !(r_out_vld && i_stall);

    for (genvar c = 0; c < NCH; c++) begin : g_chan
        always_comb begin
            op[c].data    = r_in_data;
            op[c].tick    = adv && r_in_cmd == itsw_pkg::CMD_TICK;
            op[c].wr_ctrl = adv && r_in_cmd == itsw_pkg::CMD_WRITE &&
                            r_in_port == itsw_pkg::PORT_CTRL && r_in_data[7:6] == 2'(c);
            op[c].wr_data = adv && r_in_cmd == itsw_pkg::CMD_WRITE &&
                            r_in_port == 2'(c);
        end

        itsw_channel u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (op[c]),
            .o_stat  (stat[c])
        );
    end

    always_comb begin
        rd_byte = 8'd0;
        t2      = 1'b0;
        for (int c = 0; c < NCH; c++) begin
            if (r_in_cmd == itsw_pkg::CMD_READ && r_in_port == 2'(c)) begin
                rd_byte = stat[c].rd_byte;
            end
            if (c == 2) begin
                t2 = stat[c].lvl_next;
            end
        end
        irq = r_in_cmd == itsw_pkg::CMD_TICK && stat[0].lvl_next && !stat[0].lvl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_cmd  <= i_command;
            r_in_port <= i_port;
            r_in_data <= i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_rd  <= rd_byte;
            r_out_irq <= irq;
            r_out_t2  <= t2;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_read_data  = r_out_rd;
    assign o_irq0       = r_out_irq;
    assign o_timer2_out = r_out_t2;

`ifndef SYNTHESIS
    a_irq_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_cmd != itsw_pkg::CMD_TICK) |=> !r_out_irq)
        else $error("irq0 raised by an item that is not a tick");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_cmd != itsw_pkg::CMD_READ) |=> r_out_rd == 8'd0)
        else $error("read byte nonzero for an item that is not a read");

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !adv) |=> r_in_vld && $stable(r_in_cmd) && $stable(r_in_data))
        else $error("held input item was lost or changed");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_vld && r_out_vld)
        else $error("stall raised with a free stage");
`endif

endmodule

@@ rtl/core/itsw_channel.sv @@
// ----------------------------------------------------------------------------
// itsw_channel
// One timer channel: count loading, phase counting, output level and reads.
// ----------------------------------------------------------------------------
module itsw_channel (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  itsw_pkg::t_chan_op    i_op,
    output itsw_pkg::t_chan_stat  o_stat
);

    logic [16:0] r_init;
    logic [1:0]  r_acc;
    logic [2:0]  r_mode;
    logic [7:0]  r_latch;
    logic        r_run;
    logic        r_lvl;
    logic [16:0] r_phase;
    logic [1:0]  r_ptr;

    logic [16:0] n_init;
    logic [1:0]  n_acc;
    logic [2:0]  n_mode;
    logic [7:0]  n_latch;
    logic        n_run;
    logic        n_lvl;
    logic [16:0] n_phase;
    logic [1:0]  n_ptr;

    logic [15:0] remain;
    logic [16:0] load_cnt;
    logic        load_start;
    logic [1:0]  load_ptr;
    logic [17:0] tick_p;
    logic [17:0] half;
    logic        tick_out;

    assign remain = 16'(r_init - r_phase);

    always_comb begin
        load_cnt   = r_init;
        load_start = 1'b0;
        load_ptr   = r_ptr;
        unique case (r_ptr)
            itsw_pkg::PTR_LOW: begin
                load_cnt   = {9'd0, i_op.data};
                load_start = 1'b1;
            end
            itsw_pkg::PTR_HIGH: begin
                load_cnt   = {1'b0, i_op.data, 8'd0};
                load_start = 1'b1;
            end
            itsw_pkg::PTR_PAIR_FIRST: begin
                load_cnt = {1'b0, r_init[15:8], i_op.data};
                load_ptr = itsw_pkg::PTR_PAIR_SECOND;
            end
            default: begin
                load_cnt   = {1'b0, i_op.data, r_init[7:0]};
                load_ptr   = itsw_pkg::PTR_PAIR_FIRST;
                load_start = 1'b1;
            end
        endcase
        if (load_cnt == 17'd0) begin
            load_cnt = itsw_pkg::FULL_COUNT;
        end
    end

    always_comb begin
        tick_p = {1'b0, r_phase} + 18'd1;
        if (tick_p >= {1'b0, r_init}) begin
            tick_p = 18'd0;
        end
        half     = ({1'b0, r_init} + 18'd1) >> 1;
        tick_out = r_run && (r_mode == itsw_pkg::MODE_SQUARE ||
                             r_mode == itsw_pkg::MODE_SQUARE_ALT) && (tick_p < half);
    end

    always_comb begin
        n_init  = r_init;
        n_acc   = r_acc;
        n_mode  = r_mode;
        n_latch = r_latch;
        n_run   = r_run;
        n_lvl   = r_lvl;
        n_phase = r_phase;
        n_ptr   = r_ptr;
        if (i_op.wr_ctrl) begin
            n_acc  = i_op.data[5:4];
            n_mode = i_op.data[3:1];
            unique case (i_op.data[5:4])
                itsw_pkg::ACC_LATCH: n_latch = remain[7:0];
                itsw_pkg::ACC_LOW:   n_ptr   = itsw_pkg::PTR_LOW;
                itsw_pkg::ACC_HIGH:  n_ptr   = itsw_pkg::PTR_HIGH;
                default:             n_ptr   = itsw_pkg::PTR_PAIR_FIRST;
            endcase
            if (i_op.data[5:4] != itsw_pkg::ACC_LATCH) begin
                n_run = 1'b0;
            end
        end else if (i_op.wr_data) begin
            n_init = load_cnt;
            n_ptr  = load_ptr;
            if (load_start) begin
                n_run   = 1'b1;
                n_phase = 17'd0;
            end
        end else if (i_op.tick) begin
            n_lvl = tick_out;
            if (r_run) begin
                n_phase = tick_p[16:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init  <= '0;
            r_acc   <= '0;
            r_mode  <= '0;
            r_latch <= '0;
            r_run   <= 1'b0;
            r_lvl   <= 1'b0;
            r_phase <= '0;
            r_ptr   <= itsw_pkg::PTR_LOW;
        end else begin
            r_init  <= n_init;
            r_acc   <= n_acc;
            r_mode  <= n_mode;
            r_latch <= n_latch;
            r_run   <= n_run;
            r_lvl   <= n_lvl;
            r_phase <= n_phase;
            r_ptr   <= n_ptr;
        end
    end

    always_comb begin
        case (r_acc)
            itsw_pkg::ACC_LATCH: o_stat.rd_byte = r_latch;
            itsw_pkg::ACC_HIGH:  o_stat.rd_byte = remain[15:8];
            default:             o_stat.rd_byte = remain[7:0];
        endcase
        o_stat.lvl      = r_lvl;
        o_stat.lvl_next = n_lvl;
    end

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_phase[16])
        else $error("phase left the 16-bit range");

    a_stop_on_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op.wr_ctrl && i_op.data[5:4] != itsw_pkg::ACC_LATCH) |=> !r_run)
        else $error("channel kept running after an access mode write");

    a_stopped_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op.tick && !r_run) |=> !r_lvl)
        else $error("stopped channel drove a high level");
`endif

endmodule

@@ sim/interval_timer_square_wave_tb.sv @@
// ----------------------------------------------------------------------------
// interval_timer_square_wave_tb
// Self-checking testbench for the three-channel interval timer.
// ----------------------------------------------------------------------------
// A queue of bus accesses and ticks feeds a driver that changes the inputs
// on the falling edge. The queue starts with a short directed list and goes on
// with channel programming sequences, tick bursts, reads and some noise. Each
// accepted item updates a cycle-free copy of the channel state. That copy
// gives the read byte, the channel 0 interrupt and the channel 2 level
// expected for the item. A monitor takes results on the rising edge and
// checks them in order. Both sides pause at random between items.
// ----------------------------------------------------------------------------
module interval_timer_square_wave_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NONE     = 2'd3;
    localparam logic [1:0] SEL_READBACK = 2'd3;
    localparam int         T2_CH        = (itsw_pkg::NUM_CHANNELS > 2) ? 2 : 0;
    localparam int         NUM_ITEMS    = 1750;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] port;
        logic [7:0] data;
    } t_bus_item;

    typedef struct packed {
        logic [7:0] rd;
        logic       irq;
        logic       t2;
    } t_timer_status;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_command = '0;
    logic [1:0] i_port = '0;
    logic [7:0] i_write_data = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_read_data;
    logic       o_irq0;
    logic       o_timer2_out;

    t_bus_item     pending_items[$];
    t_timer_status status_due[$];
    t_timer_status got_status;
    t_bus_item     next_item;

    logic [16:0] load_q  [itsw_pkg::NUM_CHANNELS];
    logic [1:0]  acc_q   [itsw_pkg::NUM_CHANNELS];
    logic [2:0]  mode_q  [itsw_pkg::NUM_CHANNELS];
    logic [7:0]  latch_q [itsw_pkg::NUM_CHANNELS];
    logic        run_q   [itsw_pkg::NUM_CHANNELS];
    logic        lvl_q   [itsw_pkg::NUM_CHANNELS];
    logic [16:0] phase_q [itsw_pkg::NUM_CHANNELS];
    logic [1:0]  ptr_q   [itsw_pkg::NUM_CHANNELS];

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    bit   send_calm = 1'b0;
    bit   recv_calm = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   stall_next;
    int   mismatches = 0;
    int   items_queued = 0;

    interval_timer_square_wave uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_port       (i_port),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_data  (o_read_data),
        .o_irq0       (o_irq0),
        .o_timer2_out (o_timer2_out)
    );

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [7:0] ctrl_word(logic [1:0] sel, logic [1:0] acc,
                                             logic [2:0] mode, logic bcd);
        return {sel, acc, mode, bcd};
    endfunction

    function automatic logic [15:0] count_left(int ch);
        logic [16:0] diff;
        diff = load_q[ch] - phase_q[ch];
        return diff[15:0];
    endfunction

    task automatic queue_item(logic [1:0] cmd, logic [1:0] port, logic [7:0] data);
        t_bus_item it;
        it.cmd = cmd;
        it.port = port;
        it.data = data;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic timer_step(logic [1:0] cmd, logic [1:0] port, logic [7:0] data);
        t_timer_status res;
        int            sel;
        int            ch;
        int            nxt;
        logic [15:0]   left;
        logic          lvl_new;
        res = '0;
        if (cmd == itsw_pkg::CMD_WRITE) begin
            if (port == itsw_pkg::PORT_CTRL) begin
                sel = data[7:6];
                if (data[7:6] != SEL_READBACK && sel < itsw_pkg::NUM_CHANNELS) begin
                    acc_q[sel] = data[5:4];
                    mode_q[sel] = data[3:1];
                    if (data[5:4] == itsw_pkg::ACC_LATCH) begin
                        left = count_left(sel);
                        latch_q[sel] = left[7:0];
                    end else begin
                        case (data[5:4])
                            itsw_pkg::ACC_LOW:  ptr_q[sel] = itsw_pkg::PTR_LOW;
                            itsw_pkg::ACC_HIGH: ptr_q[sel] = itsw_pkg::PTR_HIGH;
                            default:            ptr_q[sel] = itsw_pkg::PTR_PAIR_FIRST;
                        endcase
                        run_q[sel] = 1'b0;
                    end
                end
            end else if (int'(port) < itsw_pkg::NUM_CHANNELS) begin
                ch = port;
                case (ptr_q[ch])
                    itsw_pkg::PTR_LOW: begin
                        load_q[ch] = {9'd0, data};
                        run_q[ch] = 1'b1;
                        phase_q[ch] = '0;
                    end
                    itsw_pkg::PTR_HIGH: begin
                        load_q[ch] = {1'b0, data, 8'd0};
                        run_q[ch] = 1'b1;
                        phase_q[ch] = '0;
                    end
                    itsw_pkg::PTR_PAIR_FIRST: begin
                        load_q[ch] = {1'b0, load_q[ch][15:8], data};
                        ptr_q[ch] = itsw_pkg::PTR_PAIR_SECOND;
                    end
                    default: begin
                        load_q[ch] = {1'b0, data, load_q[ch][7:0]};
                        ptr_q[ch] = itsw_pkg::PTR_PAIR_FIRST;
                        run_q[ch] = 1'b1;
                        phase_q[ch] = '0;
                    end
                endcase
                if (load_q[ch] == '0) begin
                    load_q[ch] = itsw_pkg::FULL_COUNT;
                end
            end
        end else if (cmd == itsw_pkg::CMD_READ) begin
            if (port != itsw_pkg::PORT_CTRL && int'(port) < itsw_pkg::NUM_CHANNELS) begin
                ch = port;
                left = count_left(ch);
                case (acc_q[ch])
                    itsw_pkg::ACC_LATCH: res.rd = latch_q[ch];
                    itsw_pkg::ACC_HIGH:  res.rd = left[15:8];
                    default:             res.rd = left[7:0];
                endcase
            end
        end else if (cmd == itsw_pkg::CMD_TICK) begin
            for (ch = 0; ch < itsw_pkg::NUM_CHANNELS; ch++) begin
                lvl_new = 1'b0;
                if (run_q[ch]) begin
                    nxt = int'(phase_q[ch]) + 1;
                    if (nxt >= int'(load_q[ch])) begin
                        nxt = 0;
                    end
                    phase_q[ch] = 17'(nxt);
                    if (mode_q[ch] == itsw_pkg::MODE_SQUARE ||
                        mode_q[ch] == itsw_pkg::MODE_SQUARE_ALT) begin
                        lvl_new = (nxt < (int'(load_q[ch]) + 1) / 2);
                    end
                end
                if (ch == 0 && !lvl_q[0] && lvl_new) begin
                    res.irq = 1'b1;
                end
                lvl_q[ch] = lvl_new;
            end
        end
        res.t2 = (itsw_pkg::NUM_CHANNELS > 2) ? lvl_q[T2_CH] : 1'b0;
        status_due.push_back(res);
    endtask

    task automatic note_mismatch(string what, int want, int got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !in_taken)) begin
            if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_items.size() > 0) begin
                next_item = pending_items.pop_front();
                i_valid <= 1'b1;
                i_command <= next_item.cmd;
                i_port <= next_item.port;
                i_write_data <= next_item.data;
                if ($urandom_range(0, 39) == 0) begin
                    send_calm = !send_calm;
                end
                gap_left <= draw_wait(send_calm);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) begin
                if ($urandom_range(0, 39) == 0) begin
                    recv_calm = !recv_calm;
                end
                stall_next = draw_wait(recv_calm);
            end else begin
                stall_next = stall_left;
            end
            if (stall_next > 0) begin
                i_stall <= 1'b1;
                stall_left <= stall_next - 1;
            end else begin
                i_stall <= 1'b0;
                stall_left <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (status_due.size() == 0) begin
                    note_mismatch("unexpected item, read_data", 0, o_read_data);
                end else begin
                    got_status = status_due.pop_front();
                    if (o_read_data !== got_status.rd) begin
                        note_mismatch("read_data", got_status.rd, o_read_data);
                    end
                    if (o_irq0 !== got_status.irq) begin
                        note_mismatch("irq0", got_status.irq, o_irq0);
                    end
                    if (o_timer2_out !== got_status.t2) begin
                        note_mismatch("timer2_out", got_status.t2, o_timer2_out);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                timer_step(i_command, i_port, i_write_data);
            end
            in_taken <= i_valid && !o_stall;
            out_taken <= o_valid && !i_stall;
        end
    end

    initial begin
        int         r;
        int         n;
        logic [1:0] sel;
        logic [1:0] acc;
        logic [1:0] dport;
        logic [2:0] mode;
        logic [7:0] lo;
        logic [7:0] hi;

        for (int ch = 0; ch < itsw_pkg::NUM_CHANNELS; ch++) begin
            load_q[ch] = '0;
            acc_q[ch] = itsw_pkg::ACC_LATCH;
            mode_q[ch] = '0;
            latch_q[ch] = '0;
            run_q[ch] = 1'b0;
            lvl_q[ch] = 1'b0;
            phase_q[ch] = '0;
            ptr_q[ch] = itsw_pkg::PTR_LOW;
        end

        queue_item(itsw_pkg::CMD_READ, 2'd0, 8'h00);
        queue_item(itsw_pkg::CMD_WRITE, itsw_pkg::PORT_CTRL,
                   ctrl_word(2'd0, itsw_pkg::ACC_PAIR, itsw_pkg::MODE_SQUARE, 1'b0));
        queue_item(itsw_pkg::CMD_WRITE, 2'd0, 8'h04);
        queue_item(itsw_pkg::CMD_WRITE, 2'd0, 8'h00);
        repeat (3) queue_item(itsw_pkg::CMD_TICK, 2'd0, 8'h00);
        queue_item(itsw_pkg::CMD_READ, 2'd0, 8'h00);
        // A first pair byte shrinks the running count below the phase.
        queue_item(itsw_pkg::CMD_WRITE, 2'd0, 8'h01);
        queue_item(itsw_pkg::CMD_TICK, 2'd1, 8'hff);
        queue_item(itsw_pkg::CMD_WRITE, itsw_pkg::PORT_CTRL,
                   ctrl_word(2'd2, itsw_pkg::ACC_LOW, itsw_pkg::MODE_SQUARE_ALT, 1'b1));
        queue_item(itsw_pkg::CMD_WRITE, 2'd2, 8'h00);
        queue_item(itsw_pkg::CMD_TICK, 2'd0, 8'h00);
        queue_item(itsw_pkg::CMD_READ, 2'd2, 8'h00);
        queue_item(itsw_pkg::CMD_WRITE, itsw_pkg::PORT_CTRL,
                   ctrl_word(2'd1, itsw_pkg::ACC_HIGH, itsw_pkg::MODE_SQUARE, 1'b0));
        queue_item(itsw_pkg::CMD_WRITE, 2'd1, 8'hff);
        queue_item(itsw_pkg::CMD_TICK, 2'd3, 8'h00);
        queue_item(itsw_pkg::CMD_READ, 2'd1, 8'h00);
        queue_item(itsw_pkg::CMD_WRITE, itsw_pkg::PORT_CTRL,
                   ctrl_word(2'd2, itsw_pkg::ACC_LATCH, itsw_pkg::MODE_SQUARE_ALT, 1'b0));
        queue_item(itsw_pkg::CMD_READ, 2'd2, 8'h00);
        queue_item(itsw_pkg::CMD_WRITE, itsw_pkg::PORT_CTRL, 8'hff);
        queue_item(itsw_pkg::CMD_READ, itsw_pkg::PORT_CTRL, 8'h00);
        queue_item(CMD_NONE, 2'd0, 8'haa);
        queue_item(itsw_pkg::CMD_TICK, 2'd0, 8'h00);

        while (items_queued < NUM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                queue_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                           8'($urandom_range(0, 255)));
            end else if (r <= 2) begin
                sel = ($urandom_range(0, 15) == 0)
                    ? SEL_READBACK
                    : 2'($urandom_range(0, itsw_pkg::NUM_CHANNELS - 1));
                acc = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 1)) begin
                    mode = $urandom_range(0, 1) ? itsw_pkg::MODE_SQUARE
                                                : itsw_pkg::MODE_SQUARE_ALT;
                end else begin
                    mode = 3'($urandom_range(0, 7));
                end
                queue_item(itsw_pkg::CMD_WRITE, itsw_pkg::PORT_CTRL,
                           ctrl_word(sel, acc, mode, 1'($urandom_range(0, 1))));
                dport = (sel == SEL_READBACK) ? 2'($urandom_range(0, 2)) : sel;
                lo = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 12));
                hi = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
                case (acc)
                    itsw_pkg::ACC_LOW:  queue_item(itsw_pkg::CMD_WRITE, dport, lo);
                    itsw_pkg::ACC_HIGH: queue_item(itsw_pkg::CMD_WRITE, dport, hi);
                    itsw_pkg::ACC_PAIR: begin
                        queue_item(itsw_pkg::CMD_WRITE, dport, lo);
                        if ($urandom_range(0, 7) != 0) begin
                            queue_item(itsw_pkg::CMD_WRITE, dport, hi);
                        end
                    end
                    default: ;
                endcase
            end else if (r <= 7) begin
                n = $urandom_range(1, 20);
                repeat (n) queue_item(itsw_pkg::CMD_TICK, 2'($urandom_range(0, 3)),
                                      8'($urandom_range(0, 255)));
            end else if (r == 8) begin
                queue_item(itsw_pkg::CMD_WRITE, itsw_pkg::PORT_CTRL,
                           ctrl_word(2'($urandom_range(0, itsw_pkg::NUM_CHANNELS - 1)),
                                     itsw_pkg::ACC_LATCH,
                                     $urandom_range(0, 1) ? itsw_pkg::MODE_SQUARE
                                                          : itsw_pkg::MODE_SQUARE_ALT,
                                     1'($urandom_range(0, 1))));
                queue_item(itsw_pkg::CMD_READ,
                           2'($urandom_range(0, itsw_pkg::NUM_CHANNELS - 1)), 8'h00);
            end else begin
                queue_item(itsw_pkg::CMD_READ, 2'($urandom_range(0, 3)),
                           8'($urandom_range(0, 255)));
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() > 0 || i_valid) @(posedge i_clk);
        while (status_due.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
